// File: rtl/piecewise_linear_gray_map_assert.svh
// Assertion macros shared by the gray map RTL.
// Every macro samples on clk and is disabled while rst is high.
`ifndef PIECEWISE_LINEAR_GRAY_MAP_ASSERT_SVH
`define PIECEWISE_LINEAR_GRAY_MAP_ASSERT_SVH

// Same-cycle implication.
`define PLGM_ASSERT_NOW(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("plgm assertion failed");

// Next-cycle implication.
`define PLGM_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("plgm assertion failed");

`endif

// File: rtl/plgm_pkg.sv
// Shared types, constants and helpers for the piecewise-linear gray map.
// No dependencies; used by every module in rtl/.
package plgm_pkg;

  localparam int PIX_W     = 8;
  localparam int KNOT_W    = 8;
  localparam int NUM_SLOTS = 8;
  localparam int IDX_W     = 3;
  localparam int COUNT_W   = 4;
  localparam int REG_W     = NUM_SLOTS * KNOT_W;
  localparam int PROD_W    = 2 * KNOT_W;
  localparam int DIV_STEPS = KNOT_W;
  localparam int ADDR_W    = 2;

  typedef logic [ADDR_W-1:0] cfg_addr_t;
  localparam cfg_addr_t REG_KNOT_COUNT     = 2'd0;
  localparam cfg_addr_t REG_KNOT_POSITIONS = 2'd1;
  localparam cfg_addr_t REG_KNOT_VALUES    = 2'd2;

  // Knot search result.
  typedef struct packed {
    logic              direct;
    logic [IDX_W-1:0]  idx;
    logic [PIX_W-1:0]  px;
  } search_t;

  // Segment operands.
  typedef struct packed {
    logic [KNOT_W-1:0] v0;
    logic [KNOT_W-1:0] dx;
    logic [KNOT_W-1:0] dv_mag;
    logic              neg;
    logic [KNOT_W-1:0] den;
  } diff_t;

  // Product ready for division.
  typedef struct packed {
    logic [KNOT_W-1:0] v0;
    logic              neg;
    logic [KNOT_W-1:0] den;
    logic [PROD_W-1:0] prod;
  } prod_t;

  // Divider stage contents.
  typedef struct packed {
    logic [KNOT_W-1:0] v0;
    logic              neg;
    logic [KNOT_W-1:0] den;
    logic [KNOT_W-1:0] rem;
    logic [KNOT_W-1:0] low;
    logic [KNOT_W-1:0] quo;
  } div_t;

  function automatic logic [KNOT_W-1:0] knot_field(input logic [REG_W-1:0] r,
                                                   input logic [IDX_W-1:0] k);
    return r[k*KNOT_W +: KNOT_W];
  endfunction

endpackage

// File: rtl/plgm_search.sv
// Knot search and segment operand stages (two register stages).
// Depends on plgm_pkg and piecewise_linear_gray_map_assert.svh.
`include "piecewise_linear_gray_map_assert.svh"

module plgm_search #(
  parameter int MAX_KNOTS = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [plgm_pkg::PIX_W-1:0]   px,
  input  logic [plgm_pkg::COUNT_W-1:0] knot_count,
  input  logic [plgm_pkg::REG_W-1:0]   knot_positions,
  input  logic [plgm_pkg::REG_W-1:0]   knot_values,
  output logic                         out_valid,
  input  logic                         out_ready,
  output plgm_pkg::diff_t              out_data
);

  logic [plgm_pkg::COUNT_W-1:0]   n_eff;
  logic [plgm_pkg::NUM_SLOTS-1:0] hit;
  logic [plgm_pkg::IDX_W-1:0]     first_idx;
  plgm_pkg::search_t              s1_next;
  plgm_pkg::search_t              s1;
  logic                           s1_valid;
  logic                           s1_ready;
  plgm_pkg::diff_t                s2_next;
  plgm_pkg::diff_t                s2;
  logic                           s2_valid;
  logic                           s2_ready;
  logic [plgm_pkg::KNOT_W-1:0]    p0, p1, v0, v1;
  logic [plgm_pkg::IDX_W-1:0]     prev_idx;

  assign s2_ready = !s2_valid || out_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  // Stage 1: compare against all active knots, pick the first one at or above px.
  always_comb begin
    if (knot_count == '0) begin
      n_eff = plgm_pkg::COUNT_W'(1);
    end else if (knot_count > plgm_pkg::COUNT_W'(MAX_KNOTS)) begin
      n_eff = plgm_pkg::COUNT_W'(MAX_KNOTS);
    end else begin
      n_eff = knot_count;
    end
    for (int k = 0; k < plgm_pkg::NUM_SLOTS; k++) begin
      hit[k] = (plgm_pkg::COUNT_W'(k) < n_eff) &&
               (plgm_pkg::knot_field(knot_positions, plgm_pkg::IDX_W'(k)) >= px);
    end
    first_idx = '0;
    for (int k = plgm_pkg::NUM_SLOTS - 1; k >= 0; k--) begin
      if (hit[k]) first_idx = plgm_pkg::IDX_W'(k);
    end
    s1_next.px = px;
    if (hit == '0) begin
      s1_next.direct = 1'b1;
      s1_next.idx    = plgm_pkg::IDX_W'(n_eff - plgm_pkg::COUNT_W'(1));
    end else if (first_idx == '0) begin
      s1_next.direct = 1'b1;
      s1_next.idx    = '0;
    end else begin
      s1_next.direct = 1'b0;
      s1_next.idx    = first_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) s1 <= s1_next;
  end

  // Stage 2: fetch the segment ends and form the differences.
  always_comb begin
    prev_idx = s1.idx - plgm_pkg::IDX_W'(1);
    p0 = plgm_pkg::knot_field(knot_positions, prev_idx);
    p1 = plgm_pkg::knot_field(knot_positions, s1.idx);
    v0 = plgm_pkg::knot_field(knot_values, prev_idx);
    v1 = plgm_pkg::knot_field(knot_values, s1.idx);
    if (s1.direct) begin
      // zero slope: the divider passes the knot value through
      s2_next.v0     = v1;
      s2_next.dx     = '0;
      s2_next.dv_mag = '0;
      s2_next.neg    = 1'b0;
      s2_next.den    = plgm_pkg::KNOT_W'(1);
    end else begin
      s2_next.v0  = v0;
      s2_next.dx  = s1.px - p0;
      s2_next.den = p1 - p0;
      if (v1 >= v0) begin
        s2_next.dv_mag = v1 - v0;
        s2_next.neg    = 1'b0;
      end else begin
        s2_next.dv_mag = v0 - v1;
        s2_next.neg    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready) s2 <= s2_next;
  end

  assign out_valid = s2_valid;
  assign out_data  = s2;

  `PLGM_ASSERT_NOW(a_interp_not_first, s1_valid && !s1.direct,
                   s1.idx != '0 && 32'(s1.idx) < MAX_KNOTS)
  `PLGM_ASSERT_NOW(a_den_nonzero, s2_valid, s2.den != '0 && s2.dx <= s2.den)

endmodule

// File: rtl/plgm_mul.sv
// Slope multiply stage: (px - p0) * |v1 - v0|.
// Depends on plgm_pkg.
module plgm_mul (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  plgm_pkg::diff_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output plgm_pkg::prod_t out_data
);

  plgm_pkg::prod_t prod_next;
  plgm_pkg::prod_t prod;
  logic            prod_valid;

  assign in_ready = !prod_valid || out_ready;

  always_comb begin
    prod_next.v0   = in_data.v0;
    prod_next.neg  = in_data.neg;
    prod_next.den  = in_data.den;
    prod_next.prod = in_data.dx * in_data.dv_mag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (in_ready) begin
      prod_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) prod <= prod_next;
  end

  assign out_valid = prod_valid;
  assign out_data  = prod;

endmodule

// File: rtl/plgm_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on plgm_pkg and piecewise_linear_gray_map_assert.svh.
`include "piecewise_linear_gray_map_assert.svh"

module plgm_div (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  plgm_pkg::prod_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output plgm_pkg::div_t  out_data
);

  localparam int N = plgm_pkg::DIV_STEPS;

  plgm_pkg::div_t entry;
  plgm_pkg::div_t st [N];
  logic           vld [N];
  logic           rdy [N+1];

  function automatic plgm_pkg::div_t div_step(input plgm_pkg::div_t d);
    logic [plgm_pkg::KNOT_W:0] t;
    plgm_pkg::div_t            r;
    r   = d;
    t   = {d.rem, d.low[plgm_pkg::KNOT_W-1]};
    if (t >= {1'b0, d.den}) begin
      t = t - {1'b0, d.den};
      r.quo = {d.quo[plgm_pkg::KNOT_W-2:0], 1'b1};
    end else begin
      r.quo = {d.quo[plgm_pkg::KNOT_W-2:0], 1'b0};
    end
    r.rem = t[plgm_pkg::KNOT_W-1:0];
    r.low = {d.low[plgm_pkg::KNOT_W-2:0], 1'b0};
    return r;
  endfunction

  // The quotient fits in 8 bits, so the upper product byte is already below den.
  always_comb begin
    entry.v0  = in_data.v0;
    entry.neg = in_data.neg;
    entry.den = in_data.den;
    entry.rem = in_data.prod[plgm_pkg::PROD_W-1:plgm_pkg::KNOT_W];
    entry.low = in_data.prod[plgm_pkg::KNOT_W-1:0];
    entry.quo = '0;
  end

  assign rdy[N] = out_ready;

  for (genvar i = 0; i < N; i++) begin : g_stage
    plgm_pkg::div_t src;
    logic           src_valid;

    if (i == 0) begin : g_first
      assign src       = entry;
      assign src_valid = in_valid;
    end else begin : g_next
      assign src       = st[i-1];
      assign src_valid = vld[i-1];
    end

    assign rdy[i] = !vld[i] || rdy[i+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (rdy[i]) begin
        vld[i] <= src_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i]) st[i] <= div_step(src);
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[N-1];
  assign out_data  = st[N-1];

  `PLGM_ASSERT_NOW(a_rem_below_den, vld[N-1], st[N-1].rem < st[N-1].den)
  `PLGM_ASSERT_NOW(a_low_drained, vld[N-1], st[N-1].low == '0)

endmodule

// File: rtl/piecewise_linear_gray_map.sv
// Top level of the piecewise-linear gray map: config registers, pipeline, output register.
// Depends on plgm_pkg, plgm_search, plgm_mul, plgm_div and the assert header.
//
//   channel  direction  handshake            payload
//   s_*      in         s_tvalid / s_tready  s_tdata[7:0] = pixel_in
//   m_*      out        m_tvalid / m_tready  m_tdata[7:0] = pixel_out
//   cfg_*    in         cfg_wr_en            cfg_addr, cfg_wr_data[63:0]
//
// One pixel per cycle unless m_tready stalls the output; stages run search, multiply, divider, output.
// The divider, one quotient bit per stage, sets the pipeline depth.
// rst is synchronous: clears all valid bits and loads the identity curve.
// Each stage holds its item when the next one is full; empty stages fill in
// behind a stalled output, so s_tready stays high until the pipeline is full.
`include "piecewise_linear_gray_map_assert.svh"

module piecewise_linear_gray_map #(
  parameter int MAX_KNOTS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,     // [7:0] pixel_in
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_tdata,     // [7:0] pixel_out
  input  logic                          cfg_wr_en,
  input  plgm_pkg::cfg_addr_t           cfg_addr,
  input  logic [plgm_pkg::REG_W-1:0]    cfg_wr_data
);

  logic [plgm_pkg::COUNT_W-1:0] knot_count;
  logic [plgm_pkg::REG_W-1:0]   knot_positions;
  logic [plgm_pkg::REG_W-1:0]   knot_values;

  logic            srch_valid, srch_ready;
  plgm_pkg::diff_t srch_data;
  logic            mul_valid, mul_ready;
  plgm_pkg::prod_t mul_data;
  logic            div_valid, div_ready;
  plgm_pkg::div_t  div_data;

  logic [plgm_pkg::KNOT_W:0]   mag;
  logic [plgm_pkg::PIX_W-1:0]  result_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      knot_count     <= plgm_pkg::COUNT_W'(2);
      knot_positions <= plgm_pkg::REG_W'(64'hFF00);
      knot_values    <= plgm_pkg::REG_W'(64'hFF00);
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        plgm_pkg::REG_KNOT_COUNT:
          knot_count <= cfg_wr_data[plgm_pkg::COUNT_W-1:0];
        plgm_pkg::REG_KNOT_POSITIONS: knot_positions <= cfg_wr_data;
        plgm_pkg::REG_KNOT_VALUES:    knot_values    <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  plgm_search #(
    .MAX_KNOTS (MAX_KNOTS)
  ) u_search (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_tvalid),
    .in_ready       (s_tready),
    .px             (s_tdata),
    .knot_count     (knot_count),
    .knot_positions (knot_positions),
    .knot_values    (knot_values),
    .out_valid      (srch_valid),
    .out_ready      (srch_ready),
    .out_data       (srch_data)
  );

  plgm_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (srch_valid),
    .in_ready  (srch_ready),
    .in_data   (srch_data),
    .out_valid (mul_valid),
    .out_ready (mul_ready),
    .out_data  (mul_data)
  );

  plgm_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mul_valid),
    .in_ready  (mul_ready),
    .in_data   (mul_data),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_data  (div_data)
  );

  // Floor toward minus infinity: round the magnitude up on a negative slope.
  always_comb begin
    mag = {1'b0, div_data.quo} +
          (plgm_pkg::KNOT_W+1)'(div_data.neg && (div_data.rem != '0));
    if (div_data.neg) begin
      result_next = div_data.v0 - mag[plgm_pkg::PIX_W-1:0];
    end else begin
      result_next = div_data.v0 + mag[plgm_pkg::PIX_W-1:0];
    end
  end

  assign div_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (div_ready) begin
      m_tvalid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (div_ready) m_tdata <= result_next;
  end

  `PLGM_ASSERT_NOW(a_ready_chain, m_tready, s_tready)
  `PLGM_ASSERT_NEXT(a_out_follows_div, div_valid && div_ready, m_tvalid)

endmodule
